// ===== src/pldr_pkg.sv =====
// Package for the point-line distance residual unit.
// Holds widths, request/response payload types and pipeline stage types.
package pldr_pkg;

   // Coordinate format.
   localparam int CoordWidth = 32;
   localparam int FracBits   = 16;

   // Derived arithmetic widths.
   localparam int DiffW  = CoordWidth + 1;        // coordinate differences
   localparam int ProdW  = 2 * DiffW;             // products of differences
   localparam int NumW   = ProdW + 1;             // numerator and squared length
   localparam int NumLoW = (NumW + 1) / 2;        // low half of the numerator split
   localparam int NumHiW = NumW - NumLoW;         // high half of the numerator split
   localparam int RemW   = 2 * NumW;              // numerator squared
   localparam int QuotW  = 34;                    // distance, capped at 2^33
   localparam int AccW   = NumW + QuotW;          // quotient times squared length
   localparam int SumW   = NumW + 2 * QuotW + 1;  // trial subtrahend
   localparam int IdxW   = $clog2(QuotW);
   localparam int ResW   = 32;
   localparam int ParmW  = 31;

   // Request payload.
   typedef struct packed {
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic signed [CoordWidth-1:0] line_start_x;
      logic signed [CoordWidth-1:0] line_start_y;
      logic signed [CoordWidth-1:0] line_end_x;
      logic signed [CoordWidth-1:0] line_end_y;
      logic        [ParmW-1:0]      circle_radius;
      logic        [ParmW-1:0]      target_distance;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [ResW-1:0] residual;
      logic            degenerate_line;
   } rsp_type;

   // State carried through the root and divide steps.
   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [AccW-1:0]  acc;
      logic [NumW-1:0]  len_sq;
      logic [QuotW-1:0] quot;
      logic [ResW-1:0]  target;
      logic             degen;
   } root_type;

endpackage

// ===== src/pldr_front.sv =====
// Front end: differences, products, numerator magnitude and its square.
// Five register stages; depends on pldr_pkg.
module pldr_front
   import pldr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output root_type out_data
);

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   logic signed [DiffW-1:0] a_ff, b_ff, dx_ff, dy_ff;
   logic signed [DiffW-1:0] a_in, b_in, dx_in, dy_in;
   logic [ResW-1:0] tg1_ff, tg2_ff, tg3_ff, tg4_ff, tg5_ff, tg1_in;
   logic dg1_ff, dg2_ff, dg3_ff, dg4_ff, dg5_ff, dg1_in;

   logic signed [ProdW-1:0] p1_ff, p2_ff, aa_ff, bb_ff;
   logic signed [ProdW-1:0] p1_in, p2_in, aa_in, bb_in;
   logic signed [ProdW-1:0] a_w, b_w, dx_w, dy_w;

   logic signed [NumW-1:0] num_s;
   logic [NumW-1:0] num_ff, num_in, l2a_ff, l2b_ff, l2c_ff, l2_in;

   logic [NumHiW-1:0] nh;
   logic [NumLoW-1:0] nl;
   logic [2*NumHiW-1:0] hh_ff, hh_in;
   logic [NumHiW+NumLoW-1:0] hl_ff, hl_in;
   logic [2*NumLoW-1:0] ll_ff, ll_in;
   logic [RemW-1:0] rem_ff, rem_in;

   // Stall chain: a stage moves when it is empty or its successor moves.
   assign adv5     = !s5_v_ff || out_ready;
   assign adv4     = !s4_v_ff || adv5;
   assign adv3     = !s3_v_ff || adv4;
   assign adv2     = !s2_v_ff || adv3;
   assign adv1     = !s1_v_ff || adv2;
   assign in_ready = adv1;

   // Stage 1: line direction, point offset, target and degenerate check.
   always_comb begin
      a_in   = DiffW'(in_data.line_end_y) - DiffW'(in_data.line_start_y);
      b_in   = DiffW'(in_data.line_end_x) - DiffW'(in_data.line_start_x);
      dx_in  = DiffW'(in_data.point_x) - DiffW'(in_data.line_start_x);
      dy_in  = DiffW'(in_data.point_y) - DiffW'(in_data.line_start_y);
      tg1_in = ResW'(in_data.circle_radius) + ResW'(in_data.target_distance);
      dg1_in = (in_data.line_end_y == in_data.line_start_y) &&
               (in_data.line_end_x == in_data.line_start_x);
   end

   // Stage 2: the four products.
   always_comb begin
      a_w   = ProdW'(a_ff);
      b_w   = ProdW'(b_ff);
      dx_w  = ProdW'(dx_ff);
      dy_w  = ProdW'(dy_ff);
      p1_in = a_w * dx_w;
      p2_in = b_w * dy_w;
      aa_in = a_w * a_w;
      bb_in = b_w * b_w;
   end

   // Stage 3: numerator magnitude and squared line length.
   always_comb begin
      num_s  = NumW'(p1_ff) - NumW'(p2_ff);
      num_in = num_s[NumW-1] ? NumW'(-num_s) : NumW'(num_s);
      l2_in  = NumW'(aa_ff) + NumW'(bb_ff);
   end

   // Stage 4: partial products of the numerator square.
   always_comb begin
      nh    = num_ff[NumW-1:NumLoW];
      nl    = num_ff[NumLoW-1:0];
      hh_in = (2*NumHiW)'(nh) * (2*NumHiW)'(nh);
      hl_in = (NumHiW+NumLoW)'(nh) * (NumHiW+NumLoW)'(nl);
      ll_in = (2*NumLoW)'(nl) * (2*NumLoW)'(nl);
   end

   // Stage 5: sum of the partial products.
   assign rem_in = (RemW'(hh_ff) << (2*NumLoW)) + (RemW'(hl_ff) << (NumLoW+1)) +
                   RemW'(ll_ff);

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (adv1) s1_v_ff <= in_valid;
         if (adv2) s2_v_ff <= s1_v_ff;
         if (adv3) s3_v_ff <= s2_v_ff;
         if (adv4) s4_v_ff <= s3_v_ff;
         if (adv5) s5_v_ff <= s4_v_ff;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      if (adv1) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         tg1_ff <= tg1_in;
         dg1_ff <= dg1_in;
      end
      if (adv2) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         aa_ff  <= aa_in;
         bb_ff  <= bb_in;
         tg2_ff <= tg1_ff;
         dg2_ff <= dg1_ff;
      end
      if (adv3) begin
         num_ff <= num_in;
         l2a_ff <= l2_in;
         tg3_ff <= tg2_ff;
         dg3_ff <= dg2_ff;
      end
      if (adv4) begin
         hh_ff  <= hh_in;
         hl_ff  <= hl_in;
         ll_ff  <= ll_in;
         l2b_ff <= l2a_ff;
         tg4_ff <= tg3_ff;
         dg4_ff <= dg3_ff;
      end
      if (adv5) begin
         rem_ff <= rem_in;
         l2c_ff <= l2b_ff;
         tg5_ff <= tg4_ff;
         dg5_ff <= dg4_ff;
      end
   end

   assign out_valid       = s5_v_ff;
   assign out_data.rem    = rem_ff;
   assign out_data.acc    = '0;
   assign out_data.len_sq = l2c_ff;
   assign out_data.quot   = '0;
   assign out_data.target = tg5_ff;
   assign out_data.degen  = dg5_ff;

endmodule

// ===== src/pldr_root_step.sv =====
// One step of the bit-serial root-quotient: decides one distance bit.
// Keeps rem = N^2 - q^2*L2 and acc = q*L2; depends on pldr_pkg.
module pldr_root_step
   import pldr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [IdxW-1:0] bit_idx,
   input  logic            in_valid,
   output logic            in_ready,
   input  root_type        in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output root_type        out_data
);

   logic     v_ff;
   root_type d_ff, d_in;
   logic [SumW-1:0] trial;
   logic            capped, take;

   assign in_ready = !v_ff || out_ready;

   // Setting bit k adds (2^(k+1)*q + 2^(2k)) * L2 to q^2*L2.
   always_comb begin
      trial  = (SumW'(in_data.acc) << (IdxW'(1) + bit_idx)) +
               (SumW'(in_data.len_sq) << {bit_idx, 1'b0});
      capped = (bit_idx != IdxW'(QuotW - 1)) && in_data.quot[QuotW-1];
      take   = !capped && (trial <= SumW'(in_data.rem));
      d_in   = in_data;
      if (take) begin
         d_in.rem  = in_data.rem - RemW'(trial);
         d_in.acc  = in_data.acc + (AccW'(in_data.len_sq) << bit_idx);
         d_in.quot = in_data.quot | (QuotW'(1) << bit_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

// ===== src/pldr_out.sv =====
// Output stage: absolute difference from the target, saturation, response register.
// Depends on pldr_pkg.
module pldr_out
   import pldr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  root_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   logic            v_ff;
   rsp_type         d_ff, d_in;
   logic [QuotW-1:0] tgt, diff;

   assign in_ready = !v_ff || out_ready;

   // Absolute error, saturated to the result width; zero on a degenerate line.
   always_comb begin
      tgt  = QuotW'(in_data.target);
      diff = (in_data.quot > tgt) ? (in_data.quot - tgt) : (tgt - in_data.quot);
      d_in.degenerate_line = in_data.degen;
      if (in_data.degen) begin
         d_in.residual = '0;
      end else if (diff[QuotW-1:ResW] != '0) begin
         d_in.residual = '1;
      end else begin
         d_in.residual = diff[ResW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

// ===== src/point_line_distance_residual_unit.sv =====
// Point-to-line distance residual unit, top level.
// Depends on pldr_pkg, pldr_front, pldr_root_step and pldr_out.
//
// Usage: a request on req_valid/req_ready/req_data carries a point, a line
// given by two points, a radius and a target gap. The response on
// rsp_valid/rsp_ready/rsp_data returns |dist - (radius + target)|, where dist
// is the perpendicular distance truncated to an integer code and capped at
// 2^33, saturated to 32 bits. A line whose two points coincide returns
// residual 0 with degenerate_line set.
// The pipeline has five front-end stages (differences, products, numerator
// magnitude, partial products of its square, their sum), 34 root-quotient
// stages that each settle one distance bit with a wide compare and subtract,
// and the response register. Throughput is one request per cycle while the
// receiver does not stall; nothing is carried between requests.
// Every stage holds its own valid bit, so a stalled receiver only halts
// stages that are full and bubbles still close up; req_ready drops once the
// whole pipeline is full. Reset clears all valid bits; no request is lost
// or repeated across a stall.
module point_line_distance_residual_unit
   import pldr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     st_valid [QuotW+1];
   logic     st_ready [QuotW+1];
   root_type st_data  [QuotW+1];

   // Front end.
   pldr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (st_valid[0]),
      .out_ready (st_ready[0]),
      .out_data  (st_data[0])
   );

   // Root-quotient chain, most significant bit first.
   for (genvar i = 0; i < QuotW; i++) begin : g_step
      pldr_root_step u_step (
         .clock     (clock),
         .reset     (reset),
         .bit_idx   (IdxW'(QuotW - 1 - i)),
         .in_valid  (st_valid[i]),
         .in_ready  (st_ready[i]),
         .in_data   (st_data[i]),
         .out_valid (st_valid[i+1]),
         .out_ready (st_ready[i+1]),
         .out_data  (st_data[i+1])
      );
   end

   // Response register.
   pldr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid[QuotW]),
      .in_ready  (st_ready[QuotW]),
      .in_data   (st_data[QuotW]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
